FILE: rtl/cbor_item_head_encoder_unit_defines.svh
// Assertion macros shared by the CBOR head encoder RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef CBOR_ITEM_HEAD_ENCODER_UNIT_DEFINES_SVH
`define CBOR_ITEM_HEAD_ENCODER_UNIT_DEFINES_SVH

// Check a property every clock outside reset.
`define CBOR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define CBOR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cbor_he_pkg.sv
// Types and constants of the CBOR item head encoder.
// No dependencies; used by the front end, queue, back end and top level.
`default_nettype none

package cbor_he_pkg;

  typedef enum logic [2:0] {
    ACT_UINT  = 3'd0,
    ACT_SINT  = 3'd1,
    ACT_FLOAT = 3'd2,
    ACT_NULL  = 3'd3,
    ACT_TEXT  = 3'd4,
    ACT_ARRAY = 3'd5,
    ACT_MAP   = 3'd6,
    ACT_RAW   = 3'd7
  } action_e;

  localparam logic [2:0] MT_UINT  = 3'd0;
  localparam logic [2:0] MT_NINT  = 3'd1;
  localparam logic [2:0] MT_TEXT  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;

  localparam logic [4:0] AI_ONE   = 5'd24;
  localparam logic [4:0] AI_TWO   = 5'd25;
  localparam logic [4:0] AI_FOUR  = 5'd26;
  localparam logic [4:0] AI_EIGHT = 5'd27;

  localparam logic [7:0] IB_FLOAT32 = 8'hFA;
  localparam logic [7:0] IB_NULL    = 8'hF6;

  localparam int unsigned MaxArgBytes = 8;

  // One classified item: leading byte, argument left-aligned, argument byte count.
  typedef struct packed {
    logic [7:0]  init_byte;
    logic [63:0] arg;
    logic [3:0]  nbytes;
  } desc_t;

endpackage

`default_nettype wire

FILE: rtl/cbor_he_if.sv
// Valid/ready channel interfaces of the CBOR head encoder.
// Depends on nothing; used by the top level.
`default_nettype none

interface cbor_he_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [63:0] head_value;
  logic signed [63:0] signed_value;
  logic [31:0] float_bits;
  logic [7:0]  raw_byte;

  modport source (output valid, action, head_value, signed_value, float_bits, raw_byte,
                  input ready);
  modport sink (input valid, action, head_value, signed_value, float_bits, raw_byte,
                output ready);
endinterface

interface cbor_he_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/cbor_he_front.sv
// Front end: classifies an item into leading byte and argument bytes.
// Depends on cbor_he_pkg.
`default_nettype none

module cbor_he_front (
  input  wire logic [2:0]         action_i,
  input  wire logic [63:0]        head_value_i,
  input  wire logic signed [63:0] signed_value_i,
  input  wire logic [31:0]        float_bits_i,
  input  wire logic [7:0]         raw_byte_i,
  output cbor_he_pkg::desc_t      desc_o
);

  function automatic cbor_he_pkg::desc_t head(input logic [2:0] major, input logic [63:0] arg);
    cbor_he_pkg::desc_t d;
    d.init_byte = {major, 5'd0};
    d.arg       = '0;
    d.nbytes    = '0;
    priority if (arg < 64'd24) begin
      d.init_byte = {major, arg[4:0]};
    end else if (arg[63:8] == '0) begin
      d.init_byte = {major, cbor_he_pkg::AI_ONE};
      d.arg       = {arg[7:0], 56'd0};
      d.nbytes    = 4'd1;
    end else if (arg[63:16] == '0) begin
      d.init_byte = {major, cbor_he_pkg::AI_TWO};
      d.arg       = {arg[15:0], 48'd0};
      d.nbytes    = 4'd2;
    end else if (arg[63:32] == '0) begin
      d.init_byte = {major, cbor_he_pkg::AI_FOUR};
      d.arg       = {arg[31:0], 32'd0};
      d.nbytes    = 4'd4;
    end else begin
      d.init_byte = {major, cbor_he_pkg::AI_EIGHT};
      d.arg       = arg;
      d.nbytes    = 4'(cbor_he_pkg::MaxArgBytes);
    end
    return d;
  endfunction

  cbor_he_pkg::action_e act;
  logic [63:0]          sv_bits;

  assign act     = cbor_he_pkg::action_e'(action_i);
  assign sv_bits = signed_value_i;

  always_comb begin
    unique case (act)
      cbor_he_pkg::ACT_UINT:  desc_o = head(cbor_he_pkg::MT_UINT, head_value_i);
      cbor_he_pkg::ACT_SINT: begin
        if (sv_bits[63]) desc_o = head(cbor_he_pkg::MT_NINT, ~sv_bits);
        else             desc_o = head(cbor_he_pkg::MT_UINT, sv_bits);
      end
      cbor_he_pkg::ACT_FLOAT: begin
        desc_o.init_byte = cbor_he_pkg::IB_FLOAT32;
        desc_o.arg       = {float_bits_i, 32'd0};
        desc_o.nbytes    = 4'd4;
      end
      cbor_he_pkg::ACT_NULL: begin
        desc_o.init_byte = cbor_he_pkg::IB_NULL;
        desc_o.arg       = '0;
        desc_o.nbytes    = '0;
      end
      cbor_he_pkg::ACT_TEXT:  desc_o = head(cbor_he_pkg::MT_TEXT, head_value_i);
      cbor_he_pkg::ACT_ARRAY: desc_o = head(cbor_he_pkg::MT_ARRAY, head_value_i);
      cbor_he_pkg::ACT_MAP:   desc_o = head(cbor_he_pkg::MT_MAP, head_value_i);
      default: begin
        desc_o.init_byte = raw_byte_i;
        desc_o.arg       = '0;
        desc_o.nbytes    = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/cbor_he_queue.sv
// Two-entry descriptor queue between front and back end.
// Depends on cbor_he_pkg.
`default_nettype none

module cbor_he_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire cbor_he_pkg::desc_t push_desc_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output cbor_he_pkg::desc_t      head_desc_o
);

  cbor_he_pkg::desc_t entry_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;

  assign full_o      = count_q[1];
  assign empty_o     = (count_q == 2'd0);
  assign head_desc_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cbor_he_back.sv
// Back end: serializes one descriptor into bytes through an output register.
// Depends on cbor_he_pkg and cbor_item_head_encoder_unit_defines.svh.
`default_nettype none

`include "cbor_item_head_encoder_unit_defines.svh"

module cbor_he_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire cbor_he_pkg::desc_t head_desc_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_byte_o,
  output logic                    last_byte_o
);

  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [63:0] arg_q, arg_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        advance;

  assign advance     = !valid_q || out_ready_i;
  assign pop_o       = advance && (cnt_q == 4'd0) && !empty_i;
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign last_byte_o = last_q;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    arg_d   = arg_q;
    cnt_d   = cnt_q;
    if (advance) begin
      if (cnt_q != 4'd0) begin
        valid_d = 1'b1;
        byte_d  = arg_q[63:56];
        arg_d   = {arg_q[55:0], 8'd0};
        cnt_d   = cnt_q - 4'd1;
        last_d  = (cnt_q == 4'd1);
      end else if (!empty_i) begin
        valid_d = 1'b1;
        byte_d  = head_desc_i.init_byte;
        arg_d   = head_desc_i.arg;
        cnt_d   = head_desc_i.nbytes;
        last_d  = (head_desc_i.nbytes == 4'd0);
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 4'd0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    arg_q  <= arg_d;
  end

  `CBOR_ASSERT(a_cnt_range, cnt_q <= 4'(cbor_he_pkg::MaxArgBytes), "argument count out of range")
  `CBOR_ASSERT_IMP(a_cnt_valid, cnt_q != 4'd0, valid_q, "bytes pending without valid output")
  `CBOR_ASSERT_IMP(a_last_done, valid_q && last_q, cnt_q == 4'd0, "last byte flagged early")

endmodule

`default_nettype wire

FILE: rtl/cbor_item_head_encoder_unit.sv
// CBOR item head encoder, top level.
// Depends on cbor_he_pkg, cbor_he_if, cbor_he_front, cbor_he_queue, cbor_he_back.
//
// in_i carries one item request per transfer: an action code and its operand
// fields. out_o carries the encoded CBOR stream one byte per transfer, with
// last_byte set on the final byte of each item. Unused operand fields are
// ignored.
// The front end classifies each item into a leading byte and 0, 1, 2, 4 or 8
// argument bytes and pushes it into a two-entry queue; the back end pops it
// and shifts the bytes out through a registered output.
// When the queue and back end are idle, the first byte of an item passes through
// the queue entry and then the output register before it is valid. The back end
// sends one output byte per cycle while out_o is ready, so an item of 1 to 9
// bytes holds it for one output transfer per byte; single-byte items run back
// to back at one item per cycle while out_o is ready.
// in_i.ready drops only while the queue holds two items. When out_o stalls,
// the output byte holds and the queue fills before the input stalls.
// Reset empties the queue and the output register; no sweep is needed.
`default_nettype none

module cbor_item_head_encoder_unit (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  cbor_he_in_if.sink    in_i,
  cbor_he_out_if.source out_o
);

  cbor_he_pkg::desc_t front_desc;
  cbor_he_pkg::desc_t head_desc;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;

  assign in_i.ready = !q_full;

  cbor_he_front u_front (
    .action_i       (in_i.action),
    .head_value_i   (in_i.head_value),
    .signed_value_i (in_i.signed_value),
    .float_bits_i   (in_i.float_bits),
    .raw_byte_i     (in_i.raw_byte),
    .desc_o         (front_desc)
  );

  cbor_he_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_i.valid && !q_full),
    .push_desc_i (front_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_desc_o (head_desc)
  );

  cbor_he_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_desc_i (head_desc),
    .pop_o       (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .last_byte_o (out_o.last_byte)
  );

endmodule

`default_nettype wire

FILE: verif/cbor_item_head_encoder_unit_check.sv
// Stream checker for the CBOR item head encoder: watches both channels, encodes
// each accepted item itself and compares every output transfer in order.
// Depends on cbor_he_pkg and the channel interfaces in cbor_he_if.
module cbor_item_head_encoder_unit_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbor_he_in_if       in_ch,
  cbor_he_out_if      out_ch,
  output int unsigned pending_o,
  output int unsigned fail_count_o,
  output int unsigned bytes_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } stream_byte_t;

  stream_byte_t stream_q [$];
  stream_byte_t next_exp;
  int unsigned  fail_count = 0;
  int unsigned  bytes_checked = 0;

  assign pending_o       = stream_q.size();
  assign fail_count_o    = fail_count;
  assign bytes_checked_o = bytes_checked;

  function automatic void push_byte(input logic [7:0] b);
    stream_byte_t e;
    e.out_byte  = b;
    e.last_byte = 1'b0;
    stream_q.insert(stream_q.size(), e);
  endfunction

  function automatic void push_head(input logic [2:0] major, input logic [63:0] arg);
    logic [4:0] ai;
    int nargs;
    if (arg < 64'd24) begin
      ai = arg[4:0];
      nargs = 0;
    end else if (arg <= 64'hFF) begin
      ai = cbor_he_pkg::AI_ONE;
      nargs = 1;
    end else if (arg <= 64'hFFFF) begin
      ai = cbor_he_pkg::AI_TWO;
      nargs = 2;
    end else if (arg <= 64'hFFFF_FFFF) begin
      ai = cbor_he_pkg::AI_FOUR;
      nargs = 4;
    end else begin
      ai = cbor_he_pkg::AI_EIGHT;
      nargs = 8;
    end
    push_byte({major, ai});
    for (int i = nargs - 1; i >= 0; i--) push_byte(arg[8*i +: 8]);
  endfunction

  function automatic void encode_item(input cbor_he_pkg::action_e act,
                                      input logic [63:0] head,
                                      input logic [63:0] sval, input logic [31:0] fbits,
                                      input logic [7:0] rbyte);
    case (act)
      cbor_he_pkg::ACT_UINT: push_head(cbor_he_pkg::MT_UINT, head);
      cbor_he_pkg::ACT_SINT: begin
        if (!sval[63]) push_head(cbor_he_pkg::MT_UINT, sval);
        else push_head(cbor_he_pkg::MT_NINT, ~sval);
      end
      cbor_he_pkg::ACT_FLOAT: begin
        push_byte(cbor_he_pkg::IB_FLOAT32);
        push_byte(fbits[31:24]);
        push_byte(fbits[23:16]);
        push_byte(fbits[15:8]);
        push_byte(fbits[7:0]);
      end
      cbor_he_pkg::ACT_NULL:  push_byte(cbor_he_pkg::IB_NULL);
      cbor_he_pkg::ACT_TEXT:  push_head(cbor_he_pkg::MT_TEXT, head);
      cbor_he_pkg::ACT_ARRAY: push_head(cbor_he_pkg::MT_ARRAY, head);
      cbor_he_pkg::ACT_MAP:   push_head(cbor_he_pkg::MT_MAP, head);
      default:                push_byte(rbyte);
    endcase
    stream_q[stream_q.size() - 1].last_byte = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (stream_q.size() == 0) begin
          $error("out_byte: no byte expected, got 8'h%02h", out_ch.out_byte);
          fail_count++;
        end else begin
          next_exp = stream_q.pop_front();
          bytes_checked++;
          if (out_ch.out_byte !== next_exp.out_byte) begin
            $error("out_byte: expected 8'h%02h, got 8'h%02h",
                   next_exp.out_byte, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.last_byte !== next_exp.last_byte) begin
            $error("last_byte: expected %0b, got %0b",
                   next_exp.last_byte, out_ch.last_byte);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        encode_item(cbor_he_pkg::action_e'(in_ch.action), in_ch.head_value,
                    in_ch.signed_value, in_ch.float_bits, in_ch.raw_byte);
    end
  end

endmodule

FILE: verif/cbor_item_head_encoder_unit_test.sv
// Top of the CBOR item head encoder testbench: clock, reset, item stimulus and
// output back-pressure; the stream checker beside the block gives the verdict.
// Depends on cbor_he_pkg, cbor_he_if, the RTL top and the stream checker.
module cbor_item_head_encoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LongHoldCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cbor_he_in_if  in_ch ();
  cbor_he_out_if out_ch ();

  int unsigned pending;
  int unsigned fail_count;
  int unsigned bytes_checked;
  int unsigned sent_per_action [8];
  int unsigned items_sent = 0;
  bit          long_hold_req = 1'b0;
  int unsigned rx_mode;
  int unsigned rx_cycle = 0;

  cbor_item_head_encoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cbor_item_head_encoder_unit_check u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .pending_o       (pending),
    .fail_count_o    (fail_count),
    .bytes_checked_o (bytes_checked)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_arg();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 23));
      1: v = 64'($urandom_range(24, 255));
      2: v = 64'($urandom_range(256, 65535));
      3: begin
        v = {32'd0, $urandom};
        if (v < 64'h1_0000) v = v + 64'h1_0000;
      end
      4: begin
        v = rand64();
        if (v[63:32] == 32'd0) v[32] = 1'b1;
      end
      default: begin
        case ($urandom_range(0, 8))
          0: v = 64'd23;
          1: v = 64'd24;
          2: v = 64'hFF;
          3: v = 64'h100;
          4: v = 64'hFFFF;
          5: v = 64'h1_0000;
          6: v = 64'hFFFF_FFFF;
          7: v = 64'h1_0000_0000;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_item(input cbor_he_pkg::action_e act, input logic [63:0] arg);
    logic [63:0] hv;
    logic [63:0] sv;
    logic [31:0] fb;
    logic [7:0]  rb;
    hv = rand64();
    sv = rand64();
    fb = $urandom;
    rb = 8'($urandom);
    case (act)
      cbor_he_pkg::ACT_SINT:  sv = arg;
      cbor_he_pkg::ACT_FLOAT: fb = arg[31:0];
      cbor_he_pkg::ACT_RAW:   rb = arg[7:0];
      cbor_he_pkg::ACT_NULL:  ;
      default:                hv = arg;
    endcase
    @(negedge clk_i);
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.head_value   <= hv;
    in_ch.signed_value <= sv;
    in_ch.float_bits   <= fb;
    in_ch.raw_byte     <= rb;
    do @(posedge clk_i); while (!in_ch.ready);
    sent_per_action[act]++;
    items_sent++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_ch.valid        <= 1'b0;
      in_ch.action       <= 3'($urandom);
      in_ch.head_value   <= rand64();
      in_ch.signed_value <= rand64();
      in_ch.float_bits   <= $urandom;
      in_ch.raw_byte     <= 8'($urandom);
    end
  endtask

  task automatic send_random(input int unsigned count, input bit gapless);
    cbor_he_pkg::action_e act;
    logic [63:0]          arg;
    int unsigned          left;
    int unsigned          blen;
    left = count;
    while (left > 0) begin
      blen = $urandom_range(1, 12);
      if (blen > left) blen = left;
      repeat (blen) begin
        act = cbor_he_pkg::action_e'($urandom_range(0, 7));
        arg = rand_arg();
        if (act == cbor_he_pkg::ACT_SINT && $urandom_range(0, 1) == 1) arg = ~arg;
        send_item(act, arg);
      end
      left -= blen;
      if (!gapless && $urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      rx_mode = $urandom_range(0, 3);
      repeat ($urandom_range(16, 80)) begin
        @(negedge clk_i);
        rx_cycle++;
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          out_ch.ready <= 1'b0;
          repeat (LongHoldCycles) @(negedge clk_i);
        end
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.action       = cbor_he_pkg::ACT_UINT;
    in_ch.head_value   = '0;
    in_ch.signed_value = '0;
    in_ch.float_bits   = '0;
    in_ch.raw_byte     = '0;
    foreach (sent_per_action[i]) sent_per_action[i] = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(cbor_he_pkg::ACT_UINT, 64'd0);
    send_item(cbor_he_pkg::ACT_UINT, 64'd23);
    send_item(cbor_he_pkg::ACT_UINT, 64'd24);
    send_item(cbor_he_pkg::ACT_UINT, 64'hFF);
    send_item(cbor_he_pkg::ACT_UINT, 64'h100);
    send_item(cbor_he_pkg::ACT_UINT, 64'hFFFF);
    idle_cycles($urandom_range(1, 4));
    send_item(cbor_he_pkg::ACT_UINT, 64'h1_0000);
    send_item(cbor_he_pkg::ACT_UINT, 64'hFFFF_FFFF);
    send_item(cbor_he_pkg::ACT_UINT, 64'h1_0000_0000);
    send_item(cbor_he_pkg::ACT_UINT, '1);
    send_item(cbor_he_pkg::ACT_SINT, 64'd0);
    send_item(cbor_he_pkg::ACT_SINT, '1);
    send_item(cbor_he_pkg::ACT_SINT, ~64'd23);
    send_item(cbor_he_pkg::ACT_SINT, ~64'd24);
    idle_cycles($urandom_range(1, 4));
    send_item(cbor_he_pkg::ACT_SINT, 64'h8000_0000_0000_0000);
    send_item(cbor_he_pkg::ACT_SINT, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(cbor_he_pkg::ACT_SINT, 64'd1000);
    send_item(cbor_he_pkg::ACT_FLOAT, 64'd0);
    send_item(cbor_he_pkg::ACT_FLOAT, 64'hFFFF_FFFF);
    send_item(cbor_he_pkg::ACT_NULL, '0);
    send_item(cbor_he_pkg::ACT_TEXT, 64'd5);
    send_item(cbor_he_pkg::ACT_ARRAY, 64'd300);
    send_item(cbor_he_pkg::ACT_MAP, 64'd70000);
    send_item(cbor_he_pkg::ACT_RAW, 64'h00);
    send_item(cbor_he_pkg::ACT_RAW, 64'hFF);
    idle_cycles(1);
    wait_drained();

    send_random(110, 1'b0);
    idle_cycles(1);
    wait_drained();

    long_hold_req = 1'b1;
    send_random(40, 1'b1);
    send_random(110, 1'b0);
    idle_cycles(1);

    wait_drained();
    repeat (20) @(negedge clk_i);

    $display("Sent %0d items (uint %0d, sint %0d, float %0d, null %0d, text %0d, array %0d,",
             items_sent, sent_per_action[cbor_he_pkg::ACT_UINT],
             sent_per_action[cbor_he_pkg::ACT_SINT],
             sent_per_action[cbor_he_pkg::ACT_FLOAT],
             sent_per_action[cbor_he_pkg::ACT_NULL],
             sent_per_action[cbor_he_pkg::ACT_TEXT],
             sent_per_action[cbor_he_pkg::ACT_ARRAY]);
    $display("map %0d, raw %0d) with a %0d-cycle output hold; %0d stream bytes checked",
             sent_per_action[cbor_he_pkg::ACT_MAP], sent_per_action[cbor_he_pkg::ACT_RAW],
             LongHoldCycles, bytes_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cbor_he_pkg.sv
rtl/cbor_he_if.sv
rtl/cbor_he_front.sv
rtl/cbor_he_queue.sv
rtl/cbor_he_back.sv
rtl/cbor_item_head_encoder_unit.sv
verif/cbor_item_head_encoder_unit_check.sv
verif/cbor_item_head_encoder_unit_test.sv
